### rtl/core/lra_pkg.sv
// Shared types and constants for the line rasterizer with pixel addressing.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package lra_pkg;

    // Default coordinate width of the line walker.
    localparam int COORD_BITS_DEF = 12;

    // Configuration port address width and register indexes.
    localparam int APB_AW = 5;
    localparam int REG_IDX_BITS = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_FRAME_BASE = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_X_OFFSET   = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_Y_OFFSET   = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_BPP        = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_PITCH      = 3'd4;

    // Reset value of the bytes-per-pixel register.
    localparam logic [2:0] BPP_RESET = 3'd2;

    // Register file contents as seen by the address stage.
    typedef struct packed {
        logic [31:0] frame_base;
        logic [11:0] x_offset;
        logic [11:0] y_offset;
        logic [2:0]  bytes_per_pixel;
        logic [15:0] line_pitch;
    } t_cfg;

endpackage

`default_nettype wire

### rtl/core/lra_cfg.sv
// Configuration register file on an APB-style port.
// Depends on lra_pkg for register indexes and the t_cfg struct.
`default_nettype none

module lra_cfg import lra_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg                    r_cfg;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    wr_en;

    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_base      <= '0;
            r_cfg.x_offset        <= '0;
            r_cfg.y_offset        <= '0;
            r_cfg.bytes_per_pixel <= BPP_RESET;
            r_cfg.line_pitch      <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FRAME_BASE: r_cfg.frame_base      <= pwdata;
                REG_X_OFFSET:   r_cfg.x_offset        <= pwdata[11:0];
                REG_Y_OFFSET:   r_cfg.y_offset        <= pwdata[11:0];
                REG_BPP:        r_cfg.bytes_per_pixel <= pwdata[2:0];
                REG_PITCH:      r_cfg.line_pitch      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (reg_idx)
            REG_FRAME_BASE: prdata = r_cfg.frame_base;
            REG_X_OFFSET:   prdata = {20'd0, r_cfg.x_offset};
            REG_Y_OFFSET:   prdata = {20'd0, r_cfg.y_offset};
            REG_BPP:        prdata = {29'd0, r_cfg.bytes_per_pixel};
            REG_PITCH:      prdata = {16'd0, r_cfg.line_pitch};
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/lra_walk.sv
// Line walker: takes start and step requests, holds the line state and
// registers at most one pixel per request. Depends on lra_pkg.
`default_nettype none

module lra_walk import lra_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_func,
    input  wire logic [COORD_BITS-1:0] i_start_x,
    input  wire logic [COORD_BITS-1:0] i_start_y,
    input  wire logic [COORD_BITS-1:0] i_end_x,
    input  wire logic [COORD_BITS-1:0] i_end_y,
    input  wire logic [15:0]           i_pen_color,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic      [COORD_BITS-1:0] o_x,
    output logic      [COORD_BITS-1:0] o_y,
    output logic      [15:0]           o_color,
    output logic                       o_last,
    output logic                       o_busy
);

    localparam int EW = COORD_BITS + 2;

    typedef logic [COORD_BITS-1:0]  t_coord;
    typedef logic signed [EW-1:0]   t_err;

    // Line state.
    t_coord r_cur_x, r_cur_y, r_end_major, r_abs_dx, r_abs_dy;
    t_err   r_err;
    logic   r_x_neg, r_y_neg, r_x_major, r_busy;
    logic [15:0] r_color;

    // Pixel register.
    t_coord      r_px_x, r_px_y;
    logic [15:0] r_px_color;
    logic        r_px_last, r_px_valid;

    // Setup values for a start request.
    logic   s_x_neg, s_y_neg, s_x_major;
    t_coord s_dx, s_dy, s_maj, s_mnr, s_end;
    t_err   s_err;

    // Effective values: setup on start, held state on step.
    logic   start, emit, accept, e_last, err_pos;
    logic   e_x_neg, e_y_neg, e_x_major;
    t_coord e_x, e_y, e_dx, e_dy, e_end, e_maj, e_mnr, major_now;
    t_coord x_st, y_st, n_cur_x, n_cur_y;
    t_err   e_err, n_err;

    assign o_stall = r_px_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign start   = !i_func;
    assign emit    = start || r_busy;

    // Direction, deltas and initial error of a new line.
    always_comb begin
        s_x_neg   = i_end_x < i_start_x;
        s_y_neg   = i_end_y < i_start_y;
        s_dx      = s_x_neg ? i_start_x - i_end_x : i_end_x - i_start_x;
        s_dy      = s_y_neg ? i_start_y - i_end_y : i_end_y - i_start_y;
        s_x_major = s_dx >= s_dy;
        s_maj     = s_x_major ? s_dx : s_dy;
        s_mnr     = s_x_major ? s_dy : s_dx;
        s_end     = s_x_major ? i_end_x : i_end_y;
        s_err     = $signed({2'b00, s_mnr}) - $signed({3'b000, s_maj[COORD_BITS-1:1]});
    end

    // One Bresenham step from the effective state.
    always_comb begin
        e_x       = start ? i_start_x : r_cur_x;
        e_y       = start ? i_start_y : r_cur_y;
        e_dx      = start ? s_dx      : r_abs_dx;
        e_dy      = start ? s_dy      : r_abs_dy;
        e_end     = start ? s_end     : r_end_major;
        e_err     = start ? s_err     : r_err;
        e_x_neg   = start ? s_x_neg   : r_x_neg;
        e_y_neg   = start ? s_y_neg   : r_y_neg;
        e_x_major = start ? s_x_major : r_x_major;

        e_maj     = e_x_major ? e_dx : e_dy;
        e_mnr     = e_x_major ? e_dy : e_dx;
        major_now = e_x_major ? e_x : e_y;
        e_last    = major_now == e_end;
        err_pos   = e_err > 0;

        x_st = e_x_neg ? e_x - 1'b1 : e_x + 1'b1;
        y_st = e_y_neg ? e_y - 1'b1 : e_y + 1'b1;

        // The major coordinate always moves; the minor one only on positive error.
        n_cur_x = (e_x_major || err_pos) ? x_st : e_x;
        n_cur_y = (!e_x_major || err_pos) ? y_st : e_y;

        n_err = e_err - (err_pos ? $signed({2'b00, e_maj}) : t_err'(0))
              + $signed({2'b00, e_mnr});
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_px_valid <= 1'b0;
        end else begin
            if (accept && emit) begin
                r_busy <= !e_last;
            end
            if (accept && emit) begin
                r_px_valid <= 1'b1;
            end else if (!i_stall) begin
                r_px_valid <= 1'b0;
            end
        end
    end

    // Line state and pixel payload.
    always_ff @(posedge i_clk) begin
        if (accept && start) begin
            r_abs_dx    <= s_dx;
            r_abs_dy    <= s_dy;
            r_end_major <= s_end;
            r_x_neg     <= s_x_neg;
            r_y_neg     <= s_y_neg;
            r_x_major   <= s_x_major;
            r_color     <= i_pen_color;
        end
        if (accept && emit) begin
            r_cur_x    <= e_last ? e_x : n_cur_x;
            r_cur_y    <= e_last ? e_y : n_cur_y;
            r_err      <= e_last ? e_err : n_err;
            r_px_x     <= e_x;
            r_px_y     <= e_y;
            r_px_color <= start ? i_pen_color : r_color;
            r_px_last  <= e_last;
        end
    end

    assign o_valid = r_px_valid;
    assign o_x     = r_px_x;
    assign o_y     = r_px_y;
    assign o_color = r_px_color;
    assign o_last  = r_px_last;
    assign o_busy  = r_busy;

endmodule

`default_nettype wire

### rtl/core/lra_addr.sv
// Address stage: computes the framebuffer byte address of a pixel and holds
// the result in the output register. Depends on lra_pkg for t_cfg.
`default_nettype none

module lra_addr import lra_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  t_cfg                       i_cfg,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [COORD_BITS-1:0] i_x,
    input  wire logic [COORD_BITS-1:0] i_y,
    input  wire logic [15:0]           i_color,
    input  wire logic                  i_last,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic      [COORD_BITS-1:0] o_pixel_x,
    output logic      [COORD_BITS-1:0] o_pixel_y,
    output logic      [31:0]           o_byte_address,
    output logic      [15:0]           o_pixel_color,
    output logic                       o_last
);

    logic                  r_valid, r_last;
    logic [COORD_BITS-1:0] r_x, r_y;
    logic [31:0]           r_addr;
    logic [15:0]           r_color;

    logic        load;
    logic [31:0] x_sum, y_sum, x_part, y_part, n_addr;

    assign o_stall = r_valid && i_stall;
    assign load    = i_valid && !o_stall;

    // Byte address, wrapping modulo 2^32.
    always_comb begin
        x_sum  = 32'(i_x) + 32'(i_cfg.x_offset);
        y_sum  = 32'(i_y) + 32'(i_cfg.y_offset);
        x_part = 32'(x_sum * 32'(i_cfg.bytes_per_pixel));
        y_part = 32'(y_sum * 32'(i_cfg.line_pitch));
        n_addr = i_cfg.frame_base + x_part + y_part;
    end

    // Output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_x     <= i_x;
            r_y     <= i_y;
            r_addr  <= n_addr;
            r_color <= i_color;
            r_last  <= i_last;
        end
    end

    assign o_valid        = r_valid;
    assign o_pixel_x      = r_x;
    assign o_pixel_y      = r_y;
    assign o_byte_address = r_addr;
    assign o_pixel_color  = r_color;
    assign o_last         = r_last;

endmodule

`default_nettype wire

### rtl/core/line_rasterizer_with_pixel_address.sv
// Top level of the line rasterizer with pixel addressing.
// Instantiates lra_cfg, lra_walk and lra_addr; depends on lra_pkg.
//
// Usage:
// A request on the input channel with func = 0 starts a new line from
// (start_x, start_y) to (end_x, end_y) in pen_color and yields its first
// pixel. A request with func = 1 yields the next pixel of the running line;
// when no line is running it yields nothing. Each pixel carries its
// coordinates, colour, framebuffer byte address and a last flag on the
// endpoint, after which the line is finished.
// Requests are accepted one per clock while o_in_stall is low. Each pixel
// passes through the walker's pixel register, where the Bresenham step is
// done, and then the output register, where the address multiply and add
// are done.
// When the receiver raises i_out_stall, the output register holds its pixel,
// the pixel register fills behind it, and the input stall rises only once
// both are full. Reset clears both stages and leaves no line running; the
// registers return to their reset values (two bytes per pixel).
// The user must write registers over the APB-style port only while no
// request is in flight; the block itself does not enforce this.
`default_nettype none

module line_rasterizer_with_pixel_address import lra_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_AW-1:0]     paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_func,
    input  wire logic [COORD_BITS-1:0] i_start_x,
    input  wire logic [COORD_BITS-1:0] i_start_y,
    input  wire logic [COORD_BITS-1:0] i_end_x,
    input  wire logic [COORD_BITS-1:0] i_end_y,
    input  wire logic [15:0]           i_pen_color,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [COORD_BITS-1:0] o_pixel_x,
    output logic      [COORD_BITS-1:0] o_pixel_y,
    output logic      [31:0]           o_byte_address,
    output logic      [15:0]           o_pixel_color,
    output logic                       o_last
);

    t_cfg                  cfg;
    logic                  px_valid, px_stall, px_last, busy;
    logic [COORD_BITS-1:0] px_x, px_y;
    logic [15:0]           px_color;

    // Register file.
    lra_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Line walker and pixel register.
    lra_walk #(.COORD_BITS(COORD_BITS)) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_func      (i_func),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_pen_color (i_pen_color),
        .o_valid     (px_valid),
        .i_stall     (px_stall),
        .o_x         (px_x),
        .o_y         (px_y),
        .o_color     (px_color),
        .o_last      (px_last),
        .o_busy      (busy)
    );

    // Address stage and output register.
    lra_addr #(.COORD_BITS(COORD_BITS)) u_addr (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_valid        (px_valid),
        .o_stall        (px_stall),
        .i_x            (px_x),
        .i_y            (px_y),
        .i_color        (px_color),
        .i_last         (px_last),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_byte_address (o_byte_address),
        .o_pixel_color  (o_pixel_color),
        .o_last         (o_last)
    );

    // A single-point line finishes at once and leaves no line running.
    a_single_point_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_func && i_start_x == i_end_x
            && i_start_y == i_end_y |=> !busy)
        else $error("single-point line left the walker busy");

    // A step request with no line running produces no pixel.
    a_idle_step_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_func && !busy |=> !px_valid)
        else $error("step while idle produced a pixel");

    // A start request, or a step on a running line, always produces a pixel.
    a_request_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (!i_func || busy) |=> px_valid)
        else $error("accepted request produced no pixel");

    // Reset empties both stages and stops the walker.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !px_valid && !busy)
        else $error("reset left a pixel or a line in flight");

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for line_rasterizer_with_pixel_address: walks Bresenham lines
// in every octant and checks each pixel's coordinates, colour, byte address and last flag.
// Depends on lra_pkg and the RTL under rtl/core; reads no files.

module testbench;
    import lra_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = COORD_BITS_DEF;
    localparam int CMAX = (1 << CW) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int SEGMENTS = 8;
    localparam int SEGMENT_ITEMS = 190;

    // Request function codes.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    // Idling pattern per segment: sender idle and receiver stall, in percent.
    localparam int SEND_IDLE_PCT [4] = '{0, 60, 0, 21};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 60, 21};

    typedef struct packed {
        logic          func;
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        logic [CW-1:0] ex;
        logic [CW-1:0] ey;
        logic [15:0]   color;
    } t_line_req;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [31:0]   addr;
        logic [15:0]   color;
        logic          last;
    } t_pixel;

    // Clock, reset and block ports.
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_func = FUNC_STEP;
    logic [CW-1:0]     i_start_x = '0;
    logic [CW-1:0]     i_start_y = '0;
    logic [CW-1:0]     i_end_x = '0;
    logic [CW-1:0]     i_end_y = '0;
    logic [15:0]       i_pen_color = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [CW-1:0]     o_pixel_x;
    logic [CW-1:0]     o_pixel_y;
    logic [31:0]       o_byte_address;
    logic [15:0]       o_pixel_color;
    logic              o_last;

    // Request and pixel bookkeeping.
    t_line_req pending_reqs[$];
    t_pixel    expected_pixels[$];
    t_line_req req_on_bus;
    t_pixel    walk_pixel;
    t_pixel    seen_pixel;
    int        queued_cnt = 0;
    int        accepted_cnt = 0;
    int        errors = 0;
    int        cycles = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;

    // Predicted register file and line walker state.
    t_cfg          cfg_model = '{32'd0, 12'd0, 12'd0, BPP_RESET, 16'd0};
    logic [CW-1:0] w_x = '0, w_y = '0, w_end_major = '0, w_adx = '0, w_ady = '0;
    int            w_err = 0;
    bit            w_xneg = 0, w_yneg = 0, w_xmaj = 0, w_busy = 0;
    logic [15:0]   w_color = '0;

    line_rasterizer_with_pixel_address #(.COORD_BITS(CW)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_func(i_func),
        .i_start_x(i_start_x), .i_start_y(i_start_y),
        .i_end_x(i_end_x), .i_end_y(i_end_y), .i_pen_color(i_pen_color),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_pixel_x(o_pixel_x), .o_pixel_y(o_pixel_y),
        .o_byte_address(o_byte_address), .o_pixel_color(o_pixel_color),
        .o_last(o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One step along an axis; the walk never leaves the endpoints' box.
    function automatic logic [CW-1:0] nudge(logic [CW-1:0] c, bit neg);
        return neg ? c - 1'b1 : c + 1'b1;
    endfunction

    // Advance the predicted walker by one request; returns 1 when a pixel is due.
    function automatic bit walk_request(input t_line_req r, output t_pixel px);
        logic [CW-1:0] maj, mnr, major_now;
        if (r.func == FUNC_START) begin
            w_xneg = r.ex < r.sx;
            w_yneg = r.ey < r.sy;
            w_adx = w_xneg ? r.sx - r.ex : r.ex - r.sx;
            w_ady = w_yneg ? r.sy - r.ey : r.ey - r.sy;
            // Equal deltas make x the major axis.
            w_xmaj = w_adx >= w_ady;
            maj = w_xmaj ? w_adx : w_ady;
            mnr = w_xmaj ? w_ady : w_adx;
            w_end_major = w_xmaj ? r.ex : r.ey;
            w_err = int'(mnr) - int'(maj >> 1);
            w_x = r.sx;
            w_y = r.sy;
            w_color = r.color;
        end else if (!w_busy) begin
            return 1'b0;
        end
        major_now = w_xmaj ? w_x : w_y;
        px.x = w_x;
        px.y = w_y;
        // Offset sums are not wrapped; only the final address wraps at 32 bits.
        px.addr = cfg_model.frame_base
            + (32'(w_x) + 32'(cfg_model.x_offset)) * 32'(cfg_model.bytes_per_pixel)
            + (32'(w_y) + 32'(cfg_model.y_offset)) * 32'(cfg_model.line_pitch);
        px.color = w_color;
        px.last = (major_now == w_end_major);
        if (px.last) begin
            w_busy = 1'b0;
        end else begin
            maj = w_xmaj ? w_adx : w_ady;
            mnr = w_xmaj ? w_ady : w_adx;
            if (w_err > 0) begin
                if (w_xmaj) w_y = nudge(w_y, w_yneg);
                else        w_x = nudge(w_x, w_xneg);
                w_err -= int'(maj);
            end
            if (w_xmaj) w_x = nudge(w_x, w_xneg);
            else        w_y = nudge(w_y, w_yneg);
            w_err += int'(mnr);
            w_busy = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Driver: presents queued requests and predicts each one as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (walk_request(req_on_bus, walk_pixel))
                    expected_pixels.push_back(walk_pixel);
                accepted_cnt++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    req_on_bus = pending_reqs.pop_front();
                    i_in_valid  <= 1'b1;
                    i_func      <= req_on_bus.func;
                    i_start_x   <= req_on_bus.sx;
                    i_start_y   <= req_on_bus.sy;
                    i_end_x     <= req_on_bus.ex;
                    i_end_y     <= req_on_bus.ey;
                    i_pen_color <= req_on_bus.color;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every accepted pixel against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                seen_pixel = '{o_pixel_x, o_pixel_y, o_byte_address, o_pixel_color, o_last};
                if (expected_pixels.size() == 0) begin
                    $display("%0t ns: unexpected pixel, expected none, actual %0h",
                             $time, seen_pixel);
                    errors++;
                end else begin
                    walk_pixel = expected_pixels.pop_front();
                    compare_field("pixel_x", 32'(walk_pixel.x), 32'(seen_pixel.x));
                    compare_field("pixel_y", 32'(walk_pixel.y), 32'(seen_pixel.y));
                    compare_field("byte_address", walk_pixel.addr, seen_pixel.addr);
                    compare_field("pixel_color", 32'(walk_pixel.color),
                                  32'(seen_pixel.color));
                    compare_field("last", 32'(walk_pixel.last), 32'(seen_pixel.last));
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Register write: a setup phase, then an access phase.
    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FRAME_BASE: cfg_model.frame_base = val;
            REG_X_OFFSET:   cfg_model.x_offset = val[11:0];
            REG_Y_OFFSET:   cfg_model.y_offset = val[11:0];
            REG_BPP:        cfg_model.bytes_per_pixel = val[2:0];
            REG_PITCH:      cfg_model.line_pitch = val[15:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] base, input logic [31:0] xo,
                             input logic [31:0] yo, input logic [31:0] bpp,
                             input logic [31:0] pitch);
        write_reg(REG_FRAME_BASE, base);
        write_reg(REG_X_OFFSET, xo);
        write_reg(REG_Y_OFFSET, yo);
        write_reg(REG_BPP, bpp);
        write_reg(REG_PITCH, pitch);
    endtask

    // Wait until every request is taken and every pixel has come back.
    task automatic drain();
        @(negedge i_clk);
        while (accepted_cnt != queued_cnt) @(negedge i_clk);
        while (expected_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic push_req(input logic func, input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                            input logic [CW-1:0] ex, input logic [CW-1:0] ey,
                            input logic [15:0] color);
        pending_reqs.push_back('{func, sx, sy, ex, ey, color});
        queued_cnt++;
    endtask

    // Step requests carry random junk in the fields they do not use.
    task automatic push_steps(input int n);
        for (int i = 0; i < n; i++)
            push_req(FUNC_STEP, CW'($urandom), CW'($urandom), CW'($urandom),
                     CW'($urandom), 16'($urandom));
    endtask

    function automatic logic [CW-1:0] rand_coord();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? CW'(CMAX) : '0;
        return CW'($urandom);
    endfunction

    function automatic logic [CW-1:0] pick_near(logic [CW-1:0] c, int span);
        int lo, hi;
        lo = int'(c) - span;
        hi = int'(c) + span;
        if (lo < 0) lo = 0;
        if (hi > CMAX) hi = CMAX;
        return CW'($urandom_range(hi, lo));
    endfunction

    // Mostly whole lines with random content; some run on past the end, some
    // are cut short by the next start, and the rest is random requests.
    task automatic gen_lines(input int budget);
        int made, pick, span, dx, dy, len, steps;
        logic [CW-1:0] sx, sy, ex, ey;
        made = 0;
        while (made < budget) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                sx = rand_coord();
                sy = rand_coord();
                pick = $urandom_range(99);
                if (pick < 3) begin
                    ex = CW'($urandom);
                    ey = CW'($urandom);
                end else begin
                    span = (pick < 10) ? $urandom_range(300, 25) : $urandom_range(24);
                    ex = pick_near(sx, span);
                    ey = pick_near(sy, span);
                end
                dx = (ex > sx) ? int'(ex - sx) : int'(sx - ex);
                dy = (ey > sy) ? int'(ey - sy) : int'(sy - ey);
                len = ((dx > dy) ? dx : dy) + 1;
                push_req(FUNC_START, sx, sy, ex, ey, 16'($urandom));
                pick = $urandom_range(99);
                if (pick < 75)
                    steps = len - 1;
                else if (pick < 90)
                    steps = len - 1 + $urandom_range(3, 1);
                else
                    steps = $urandom_range(len - 1);
                if (steps > 400) steps = 400;
                // Keep the segment close to its request budget.
                if (steps > budget - made - 1) steps = budget - made - 1;
                push_steps(steps);
                made += 1 + ((steps < len - 1) ? steps : len - 1);
            end else begin
                push_req(1'($urandom_range(1)), CW'($urandom), CW'($urandom),
                         CW'($urandom), CW'($urandom), 16'($urandom));
                made++;
            end
        end
    endtask

    // Register settings per segment, extremes first.
    task automatic configure(input int seg);
        logic [31:0] bpp;
        case (seg)
            0: write_all('1, '1, '1, '1, '1);
            1: write_all('0, '0, '0, '0, '0);
            default: begin
                if (seg == 2) begin
                    // Writes to unused register slots must leave everything unchanged.
                    for (int i = REG_PITCH + 1; i < (1 << REG_IDX_BITS); i++)
                        write_reg(REG_IDX_BITS'(i), $urandom);
                end
                bpp = ($urandom_range(9) < 8) ? $urandom_range(4, 1) : $urandom_range(7);
                write_all($urandom, $urandom, $urandom, ($urandom & ~32'h7) | bpp, $urandom);
            end
        endcase
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines under the reset register values.
        @(negedge i_clk);
        push_steps(1);                                    // step with no line running
        push_req(FUNC_START, CW'(0), CW'(0), CW'(0), CW'(0), 16'h0000); // single-point line
        push_steps(1);                                    // engine must stay idle
        push_req(FUNC_START, CW'(CMAX), CW'(CMAX), CW'(CMAX), CW'(CMAX), 16'hFFFF);
        push_req(FUNC_START, CW'(10), CW'(10), CW'(13), CW'(13), 16'h5A5A); // equal deltas
        push_steps(3);
        push_req(FUNC_START, CW'(CMAX), CW'(CMAX), CW'(CMAX - 1), CW'(CMAX - 5), 16'hA5A5);
        push_steps(5);
        // Dropped by the next start.
        push_req(FUNC_START, CW'(0), CW'(CMAX), CW'(CMAX), CW'(0), 16'h1234);
        push_steps(2);
        push_req(FUNC_START, CW'(100), CW'(0), CW'(97), CW'(2), 16'hC3C3);
        push_steps(3);
        drain();

        // Random segments; each one changes the registers while idle.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            configure(seg);
            @(negedge i_clk);
            idle_pct = SEND_IDLE_PCT[seg % 4];
            stall_pct = RECV_STALL_PCT[seg % 4];
            gen_lines(SEGMENT_ITEMS);
            drain();
        end

        if (errors == 0 && expected_pixels.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
